// File: rtl/assert_macros.svh
// Assertion macros used by the scanner's RTL (included by pss_engine).
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold on every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/pss_pkg.sv
// Types, constants and helper functions of the printable string scanner.
package pss_pkg;

   // Width of the byte offset counters
   localparam int ADDR_WIDTH = 32;

   // Configuration port
   localparam int CSR_ADDR_WIDTH = 4;
   localparam int CSR_DATA_WIDTH = 32;

   localparam logic [1:0] REG_MIN_CHARS = 2'd0;
   localparam logic [1:0] REG_NEED_TERM = 2'd1;
   localparam logic [1:0] REG_SCAN_MODE = 2'd2;

   localparam logic [11:0] MIN_CHARS_RESET = 12'd3;
   localparam logic        NEED_TERM_RESET = 1'b0;
   localparam logic [1:0]  SCAN_MODE_RESET = 2'd3;

   // scan_mode bits
   localparam int MODE_ASCII_BIT = 0;
   localparam int MODE_WIDE_BIT  = 1;

   // Result kinds
   localparam logic KIND_ASCII = 1'b0;
   localparam logic KIND_WIDE  = 1'b1;

   // Printable character range
   localparam logic [7:0] CHAR_FIRST = 8'h20;
   localparam logic [7:0] CHAR_LAST  = 8'h7E;
   localparam logic [7:0] NUL_BYTE   = 8'h00;

   // Result queue
   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_WIDE,
      PH_ASCII
   } phase_type;

   typedef struct packed {
      logic [11:0] min_chars;
      logic        need_terminator;
      logic [1:0]  scan_mode;
   } config_type;

   typedef struct packed {
      logic        kind;
      logic [31:0] start_address;
      logic [31:0] char_count;
      logic        last_flag;
   } result_type;

   function automatic logic is_printable(logic [7:0] b);
      return b inside {[CHAR_FIRST:CHAR_LAST]};
   endfunction

   // Saturating character count increment
   function automatic logic [31:0] sat_inc(logic [31:0] v);
      return (v == '1) ? v : v + 32'd1;
   endfunction

endpackage

// File: rtl/pss_engine.sv
// Scan engine: per-byte run detection with one held lookahead byte.
`include "assert_macros.svh"

module pss_engine (
   input  logic                     clock,
   input  logic                     reset,
   input  pss_pkg::config_type      cfg,
   input  logic                     advance,
   input  logic [7:0]               data_byte,
   input  logic                     end_of_data,
   output pss_pkg::result_type [1:0] results,
   output logic [1:0]               result_count
);
   import pss_pkg::*;

   phase_type             phase_ff, phase_in;
   logic                  held_valid_ff, held_valid_in;
   logic [7:0]            held_byte_ff, held_byte_in;
   logic [ADDR_WIDTH-1:0] pos_ff, pos_in;
   logic [ADDR_WIDTH-1:0] start_ff, start_in;
   logic [31:0]           len_ff, len_in;

   function automatic logic reaches_min(logic [31:0] ln, logic [11:0] minv);
      return ln >= 32'(minv);
   endfunction

   function automatic result_type make_result(logic kind, logic [ADDR_WIDTH-1:0] st,
                                              logic [31:0] ln);
      result_type r;
      r.kind          = kind;
      r.start_address = 32'(st);
      r.char_count    = ln;
      r.last_flag     = 1'b0;
      return r;
   endfunction

   // Walk the held byte (if any) and the new byte through the scan phases
   always_comb begin
      phase_type             ph;
      logic [ADDR_WIDTH-1:0] pos;
      logic [ADDR_WIDTH-1:0] st;
      logic [31:0]           ln;
      logic [1:0]            n;
      result_type [1:0]      res;
      logic                  y_todo;
      logic                  hold_req;
      logic [11:0]           minv;
      logic                  nt;
      logic                  mode_a;
      logic                  mode_w;
      logic [7:0]            x;
      logic [7:0]            y;
      logic                  e;

      ph       = phase_ff;
      pos      = pos_ff;
      st       = start_ff;
      ln       = len_ff;
      n        = 2'd0;
      res      = '0;
      y_todo   = 1'b1;
      hold_req = 1'b0;
      minv     = (cfg.min_chars == '0) ? 12'd1 : cfg.min_chars;
      nt       = cfg.need_terminator;
      mode_a   = cfg.scan_mode[MODE_ASCII_BIT];
      mode_w   = cfg.scan_mode[MODE_WIDE_BIT];
      x        = held_byte_ff;
      y        = data_byte;
      e        = end_of_data;

      // Held byte: finish the pending wide pair decision
      if (held_valid_ff) begin
         if (is_printable(x) && y == NUL_BYTE) begin
            ln     = sat_inc(ln);
            pos    = pos + ADDR_WIDTH'(2);
            y_todo = 1'b0;
         end else begin
            if (reaches_min(ln, minv) && (!nt || (x == NUL_BYTE && y == NUL_BYTE))) begin
               res[0] = make_result(KIND_WIDE, st, ln);
               n      = 2'd1;
            end
            // pair given back: a printable held byte opens a fresh ASCII attempt if ASCII mode is on
            if (mode_a) begin
               st = pos;
               ln = is_printable(x) ? 32'd1 : 32'd0;
               ph = is_printable(x) ? PH_ASCII : PH_IDLE;
            end else begin
               ph = PH_IDLE;
            end
            pos = pos + ADDR_WIDTH'(1);
         end
      end

      // New byte: start a run attempt when seeking
      if (y_todo && ph == PH_IDLE) begin
         st = pos;
         ln = '0;
         if (mode_w) begin
            ph = PH_WIDE;
         end else if (mode_a) begin
            ph = PH_ASCII;
         end else begin
            pos    = pos + ADDR_WIDTH'(1);
            y_todo = 1'b0;
         end
      end

      // New byte in a wide attempt with no second byte to hand
      if (y_todo && ph == PH_WIDE) begin
         if ((!e && is_printable(y)) ||
             (reaches_min(ln, minv) && nt && !e && y == NUL_BYTE)) begin
            hold_req = 1'b1;
            y_todo   = 1'b0;
         end else begin
            if (reaches_min(ln, minv) && !nt && n != 2'd2) begin
               res[n[0]] = make_result(KIND_WIDE, st, ln);
               n         = n + 2'd1;
            end
            if (mode_a) begin
               ph = PH_ASCII;
               st = pos;
               ln = '0;
            end else begin
               ph     = PH_IDLE;
               pos    = pos + ADDR_WIDTH'(1);
               y_todo = 1'b0;
            end
         end
      end

      // New byte in an ASCII run
      if (y_todo && ph == PH_ASCII) begin
         if (is_printable(y)) begin
            ln = sat_inc(ln);
         end else begin
            if (reaches_min(ln, minv) && (!nt || y == NUL_BYTE) && n != 2'd2) begin
               res[n[0]] = make_result(KIND_ASCII, st, ln);
               n         = n + 2'd1;
            end
            ph = PH_IDLE;
         end
         pos = pos + ADDR_WIDTH'(1);
      end

      // End of data: flush an open run, then start over at offset zero
      if (e && !hold_req) begin
         if (!nt && reaches_min(ln, minv) && n != 2'd2) begin
            if (ph == PH_WIDE) begin
               res[n[0]] = make_result(KIND_WIDE, st, ln);
               n         = n + 2'd1;
            end else if (ph == PH_ASCII) begin
               res[n[0]] = make_result(KIND_ASCII, st, ln);
               n         = n + 2'd1;
            end
         end
         ph  = PH_IDLE;
         pos = '0;
         st  = '0;
         ln  = '0;
      end

      if (n != 2'd0) begin
         res[1'(n - 2'd1)].last_flag = 1'b1;
      end

      phase_in      = ph;
      pos_in        = pos;
      start_in      = st;
      len_in        = ln;
      held_valid_in = hold_req;
      held_byte_in  = hold_req ? y : '0;
      results       = res;
      result_count  = n;
   end

   // Scan state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_IDLE;
         held_valid_ff <= 1'b0;
         held_byte_ff  <= '0;
         pos_ff        <= '0;
         start_ff      <= '0;
         len_ff        <= '0;
      end else if (advance) begin
         phase_ff      <= phase_in;
         held_valid_ff <= held_valid_in;
         held_byte_ff  <= held_byte_in;
         pos_ff        <= pos_in;
         start_ff      <= start_in;
         len_ff        <= len_in;
      end
   end

   // A byte is held only while a wide pair waits for its second byte
   `ASSERT_IMPLIES(a_held_in_wide, clock, reset, held_valid_ff, phase_ff == PH_WIDE,
                   "held byte outside wide phase")
   // The last byte of the data leaves the scanner in its start state
   `ASSERT_NEXT(a_end_restarts, clock, reset, advance && end_of_data,
                pos_ff == '0 && !held_valid_ff && phase_ff == PH_IDLE,
                "scan state not cleared after end of data")
   // State moves only when a byte is processed
   `ASSERT_NEXT(a_state_holds, clock, reset, !advance,
                $stable(pos_ff) && $stable(phase_ff) && $stable(len_ff),
                "scan state changed without a byte")

endmodule

// File: rtl/pss_result_fifo.sv
// Four-entry result queue taking up to two results per cycle.
module pss_result_fifo (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [1:0]                    push_count,
   input  pss_pkg::result_type [1:0]     push_data,
   input  logic                          pop,
   output logic                          head_valid,
   output pss_pkg::result_type           head_data,
   output logic [pss_pkg::FIFO_PTR_W:0]  fill_count
);
   import pss_pkg::*;

   result_type            mem_ff [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [FIFO_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [FIFO_PTR_W:0]   count_ff, count_in;

   // Pointer and fill arithmetic
   always_comb begin
      wr_ptr_in = wr_ptr_ff + FIFO_PTR_W'(push_count);
      rd_ptr_in = rd_ptr_ff + FIFO_PTR_W'(pop);
      count_in  = count_ff + (FIFO_PTR_W + 1)'(push_count) - (FIFO_PTR_W + 1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage: first result at the write pointer, second just after it
   always_ff @(posedge clock) begin
      if (push_count != 2'd0) begin
         mem_ff[wr_ptr_ff] <= push_data[0];
      end
      if (push_count == 2'd2) begin
         mem_ff[wr_ptr_ff + FIFO_PTR_W'(1)] <= push_data[1];
      end
   end

   assign head_valid = (count_ff != '0);
   assign head_data  = mem_ff[rd_ptr_ff];
   assign fill_count = count_ff;

endmodule

// File: rtl/printable_string_scanner.sv
// Top level of the printable string scanner: CSRs, input register, engine, result queue.
//
// Bytes enter on req_ (tdata = data_byte, tlast = end of data), one per transfer.
// Each accepted byte is registered, then scanned once the result queue has room; any runs it
// closes are queued and leave on rsp_ (tdata = start address and character count,
// tuser = kind, tlast = last result caused by that byte).
// Throughput: one byte per cycle; a byte may cause up to two results and the result
// channel moves one per cycle, so sustained rate is set by the result queue drain.
// A byte's results pass through the input register and the result queue before rsp_ offers them.
// The input register holds its byte while the four-entry result queue lacks room for
// that byte's results; req_tready then drops, so a stalled receiver fills the queue
// and throttles the input without losing or reordering anything.
// Configuration (APB-style, pready always high): min_chars at 0x0, need_terminator
// at 0x4, scan_mode at 0x8; write only while idle.
// Reset (synchronous, active high) restores the register defaults (3, 0, 3), empties
// the queue and restarts the byte offset at zero, as does the last byte of the data.
module printable_string_scanner (
   input  logic                                clock,
   input  logic                                reset,
   // input stream
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [7:0]                          req_tdata,   // [7:0] data_byte
   input  logic                                req_tlast,   // end_of_data
   // result stream
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [63:0]                         rsp_tdata,   // [31:0] start_address, [63:32] char_count
   output logic                                rsp_tuser,   // string_kind
   output logic                                rsp_tlast,   // final_of_burst
   // configuration port
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [pss_pkg::CSR_ADDR_WIDTH-1:0]  csr_paddr,
   input  logic [pss_pkg::CSR_DATA_WIDTH-1:0]  csr_pwdata,
   output logic [pss_pkg::CSR_DATA_WIDTH-1:0]  csr_prdata,
   output logic                                csr_pready
);
   import pss_pkg::*;

   config_type          cfg_ff, cfg_in;
   logic                in_valid_ff, in_valid_in;
   logic [7:0]          in_byte_ff, in_byte_in;
   logic                in_end_ff, in_end_in;
   logic                advance;
   logic                pop;
   logic                room;
   logic [1:0]          result_count;
   result_type [1:0]    results;
   result_type          head;
   logic                head_valid;
   logic [FIFO_PTR_W:0] fill_count;
   logic [1:0]          reg_index;

   // Configuration registers
   assign csr_pready = 1'b1;
   assign reg_index  = csr_paddr[3:2];

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
         case (reg_index)
            REG_MIN_CHARS: cfg_in.min_chars       = csr_pwdata[11:0];
            REG_NEED_TERM: cfg_in.need_terminator = csr_pwdata[0];
            REG_SCAN_MODE: cfg_in.scan_mode       = csr_pwdata[1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_index)
         REG_MIN_CHARS: csr_prdata = CSR_DATA_WIDTH'(cfg_ff.min_chars);
         REG_NEED_TERM: csr_prdata = CSR_DATA_WIDTH'(cfg_ff.need_terminator);
         REG_SCAN_MODE: csr_prdata = CSR_DATA_WIDTH'(cfg_ff.scan_mode);
         default:       csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.min_chars       <= MIN_CHARS_RESET;
         cfg_ff.need_terminator <= NEED_TERM_RESET;
         cfg_ff.scan_mode       <= SCAN_MODE_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Input register: advances once the queue can take this byte's results
   assign pop        = rsp_tvalid && rsp_tready;
   assign room       = ({1'b0, fill_count} + 4'(result_count) - 4'(pop)) <= 4'(FIFO_DEPTH);
   assign advance    = in_valid_ff && room;
   assign req_tready = !in_valid_ff || advance;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_byte_in  = in_byte_ff;
      in_end_in   = in_end_ff;
      if (req_tvalid && req_tready) begin
         in_valid_in = 1'b1;
         in_byte_in  = req_tdata;
         in_end_in   = req_tlast;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
      in_byte_ff <= in_byte_in;
      in_end_ff  <= in_end_in;
   end

   pss_engine u_engine (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg_ff),
      .advance      (advance),
      .data_byte    (in_byte_ff),
      .end_of_data  (in_end_ff),
      .results      (results),
      .result_count (result_count)
   );

   pss_result_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_count (advance ? result_count : 2'd0),
      .push_data  (results),
      .pop        (pop),
      .head_valid (head_valid),
      .head_data  (head),
      .fill_count (fill_count)
   );

   // Result channel
   assign rsp_tvalid = head_valid;
   assign rsp_tdata  = {head.char_count, head.start_address};
   assign rsp_tuser  = head.kind;
   assign rsp_tlast  = head.last_flag;

endmodule

// File: tb/sv/pss_run_checker.sv
// Scoreboard for the printable string scanner: predicts reported runs and checks the rsp_ stream.
`timescale 1ns / 100ps
module pss_run_checker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   input  logic                                req_tready,
   input  logic [7:0]                          req_tdata,   // [7:0] data_byte
   input  logic                                req_tlast,   // end_of_data
   input  logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   input  logic [63:0]                         rsp_tdata,   // [31:0] start_address, [63:32] char_count
   input  logic                                rsp_tuser,   // string_kind
   input  logic                                rsp_tlast,   // final_of_burst
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [pss_pkg::CSR_ADDR_WIDTH-1:0]  csr_paddr,
   input  logic [pss_pkg::CSR_DATA_WIDTH-1:0]  csr_pwdata,
   input  logic                                csr_pready,
   output int                                  mismatch_count,
   output int                                  runs_pending
);
   import pss_pkg::*;

   localparam int MAX_REPORTED = 10;

   // shadow registers and scan state
   config_type              cfg;
   logic [ADDR_WIDTH-1:0]   byte_pos;
   logic [ADDR_WIDTH-1:0]   run_start;
   logic [31:0]             run_len;
   phase_type               scan_state;
   logic [7:0]              held [2];
   int                      held_n;

   result_type              expected_runs [$];
   result_type              burst_runs [$];

   function automatic logic in_print_range(logic [7:0] b);
      return (b >= CHAR_FIRST) && (b <= CHAR_LAST);
   endfunction

   task automatic restart_scan();
      byte_pos   = '0;
      run_start  = '0;
      run_len    = '0;
      scan_state = PH_IDLE;
      held[0]    = '0;
      held[1]    = '0;
      held_n     = 0;
   endtask

   // at most two runs are reported per byte
   task automatic note_run(input logic kind);
      result_type r;
      if (burst_runs.size() < 2) begin
         r.kind          = kind;
         r.start_address = run_start[31:0];
         r.char_count    = run_len;
         r.last_flag     = 1'b0;
         burst_runs.push_back(r);
      end
   endtask

   // Advance the scan by one byte and queue the runs that it closes
   task automatic predict_runs(input logic [7:0] data_byte, input logic end_of_data);
      logic [7:0]  window [3];
      int          fill;
      int          head;
      logic        stalled;
      logic        at_last;
      logic        handled;
      logic [7:0]  x;
      logic [31:0] floor_len;
      result_type  r;
      fill    = 0;
      head    = 0;
      stalled = 1'b0;
      floor_len = (cfg.min_chars == 0) ? 32'd1 : 32'(cfg.min_chars);
      burst_runs.delete();

      for (int i = 0; i < held_n; i++) begin
         window[fill] = held[i];
         fill++;
      end
      window[fill] = data_byte;
      fill++;

      while (head < fill && !stalled) begin
         x       = window[head];
         at_last = end_of_data && (head == fill - 1);
         case (scan_state)
            PH_IDLE: begin
               run_start = byte_pos;
               run_len   = '0;
               if (cfg.scan_mode[MODE_WIDE_BIT]) begin
                  scan_state = PH_WIDE;
               end else if (cfg.scan_mode[MODE_ASCII_BIT]) begin
                  scan_state = PH_ASCII;
               end else begin
                  head++;
                  byte_pos = byte_pos + 1'b1;
               end
            end
            PH_WIDE: begin
               handled = 1'b0;
               // extend by a printable byte followed by a zero
               if (!at_last && in_print_range(x)) begin
                  if (head + 1 >= fill) begin
                     stalled = 1'b1;
                     handled = 1'b1;
                  end else if (window[head+1] == NUL_BYTE) begin
                     if (run_len != '1) run_len = run_len + 1'b1;
                     head += 2;
                     byte_pos = byte_pos + 2'd2;
                     handled  = 1'b1;
                  end
               end
               // wide attempt stopped here: report it if long enough
               if (!handled && run_len >= floor_len) begin
                  if (!cfg.need_terminator) begin
                     note_run(KIND_WIDE);
                     scan_state = PH_IDLE;
                     handled    = 1'b1;
                  end else if (!at_last && x == NUL_BYTE) begin
                     if (head + 1 >= fill) begin
                        stalled = 1'b1;
                        handled = 1'b1;
                     end else if (window[head+1] == NUL_BYTE) begin
                        note_run(KIND_WIDE);
                        scan_state = PH_IDLE;
                        handled    = 1'b1;
                     end
                  end
               end
               // otherwise fall back to ASCII from the stop point, or skip a byte
               if (!handled) begin
                  if (cfg.scan_mode[MODE_ASCII_BIT]) begin
                     scan_state = PH_ASCII;
                     run_start  = byte_pos;
                     run_len    = '0;
                  end else begin
                     head++;
                     byte_pos   = byte_pos + 1'b1;
                     scan_state = PH_IDLE;
                  end
               end
            end
            default: begin
               if (in_print_range(x)) begin
                  if (run_len != '1) run_len = run_len + 1'b1;
                  head++;
                  byte_pos = byte_pos + 1'b1;
               end else if (run_len >= floor_len &&
                            (!cfg.need_terminator || x == NUL_BYTE)) begin
                  note_run(KIND_ASCII);
                  scan_state = PH_IDLE;
               end else begin
                  head++;
                  byte_pos   = byte_pos + 1'b1;
                  scan_state = PH_IDLE;
               end
            end
         endcase
      end

      // keep unscanned bytes for lookahead
      held[0] = '0;
      held[1] = '0;
      held_n  = 0;
      for (int i = head; i < fill && held_n < 2; i++) begin
         held[held_n] = window[i];
         held_n++;
      end

      // open run at end of data, then a fresh data block
      if (end_of_data && !stalled) begin
         if (!cfg.need_terminator && run_len >= floor_len) begin
            if (scan_state == PH_WIDE) note_run(KIND_WIDE);
            else if (scan_state == PH_ASCII) note_run(KIND_ASCII);
         end
         restart_scan();
      end

      if (burst_runs.size() > 0) begin
         r = burst_runs.pop_back();
         r.last_flag = 1'b1;
         burst_runs.push_back(r);
      end
      foreach (burst_runs[i]) expected_runs.push_back(burst_runs[i]);
   endtask

   // Watch all three ports at each edge
   always @(posedge clock) begin : watch
      result_type seen;
      result_type want;
      logic       bad;
      if (reset) begin
         cfg.min_chars       = MIN_CHARS_RESET;
         cfg.need_terminator = NEED_TERM_RESET;
         cfg.scan_mode       = SCAN_MODE_RESET;
         restart_scan();
         expected_runs.delete();
         mismatch_count <= 0;
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_paddr[CSR_ADDR_WIDTH-1:2])
               REG_MIN_CHARS: cfg.min_chars       = csr_pwdata[11:0];
               REG_NEED_TERM: cfg.need_terminator = csr_pwdata[0];
               REG_SCAN_MODE: cfg.scan_mode       = csr_pwdata[1:0];
               default: ;
            endcase
         end

         if (req_tvalid && req_tready) predict_runs(req_tdata, req_tlast);

         // compare each result transfer with the oldest expectation
         if (rsp_tvalid && rsp_tready) begin
            seen.kind          = rsp_tuser;
            seen.start_address = rsp_tdata[31:0];
            seen.char_count    = rsp_tdata[63:32];
            seen.last_flag     = rsp_tlast;
            if (expected_runs.size() == 0) begin
               bad = 1'b1;
               if (mismatch_count < MAX_REPORTED)
                  $display("%0t: unexpected run kind %0d start %0d count %0d last %0d",
                           $time, seen.kind, seen.start_address, seen.char_count,
                           seen.last_flag);
            end else begin
               want = expected_runs.pop_front();
               bad  = (seen.kind !== want.kind) ||
                      (seen.start_address !== want.start_address) ||
                      (seen.char_count !== want.char_count) ||
                      (seen.last_flag !== want.last_flag);
               if (bad && mismatch_count < MAX_REPORTED)
                  $display({"%0t: run mismatch, expected kind %0d start %0d count %0d",
                            " last %0d, got %0d %0d %0d %0d"},
                           $time, want.kind, want.start_address, want.char_count,
                           want.last_flag, seen.kind, seen.start_address,
                           seen.char_count, seen.last_flag);
            end
            if (bad) mismatch_count <= mismatch_count + 1;
         end
      end
      runs_pending <= expected_runs.size();
   end

endmodule

// File: tb/sv/printable_string_scanner_tb.sv
// Testbench top for the printable string scanner: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps
module printable_string_scanner_tb;
   import pss_pkg::*;

   localparam int CYCLE_LIMIT  = 500000;
   localparam int DRAIN_CYCLES = 8;
   localparam int MAX_GAP      = 40;

   logic                      clock       = 1'b0;
   logic                      reset       = 1'b1;
   logic                      req_tvalid  = 1'b0;
   logic                      req_tready;
   logic [7:0]                req_tdata   = '0;   // [7:0] data_byte
   logic                      req_tlast   = 1'b0; // end_of_data
   logic                      rsp_tvalid;
   logic                      rsp_tready  = 1'b0;
   logic [63:0]               rsp_tdata;          // [31:0] start_address, [63:32] char_count
   logic                      rsp_tuser;          // string_kind
   logic                      rsp_tlast;          // final_of_burst
   logic                      csr_psel    = 1'b0;
   logic                      csr_penable = 1'b0;
   logic                      csr_pwrite  = 1'b0;
   logic [CSR_ADDR_WIDTH-1:0] csr_paddr   = '0;
   logic [CSR_DATA_WIDTH-1:0] csr_pwdata  = '0;
   logic [CSR_DATA_WIDTH-1:0] csr_prdata;
   logic                      csr_pready;

   int mismatch_count;
   int runs_pending;
   int items_sent  = 0;
   int idle_pct    = 0;
   int stall_pct   = 0;
   int cycle_count = 0;

   printable_string_scanner u_top (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   pss_run_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tlast      (req_tlast),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tuser      (rsp_tuser),
      .rsp_tlast      (rsp_tlast),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .csr_pready     (csr_pready),
      .mismatch_count (mismatch_count),
      .runs_pending   (runs_pending)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // receiver back-pressure
   always @(posedge clock) begin
      if (reset) rsp_tready <= 1'b0;
      else rsp_tready <= ($urandom_range(99) >= stall_pct);
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   function automatic logic [7:0] printable_byte();
      logic [7:0] c;
      c = 8'($urandom_range(CHAR_LAST, CHAR_FIRST));
      return c;
   endfunction

   // Register write: setup, access, then a quiet wait with the port deselected
   task automatic csr_write(input logic [1:0] reg_index, input logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {reg_index, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   // One byte transfer, after a random idle gap
   task automatic send_byte(input logic [7:0] data_byte, input logic end_of_data);
      int gap;
      gap = 0;
      while (gap < MAX_GAP && $urandom_range(99) < idle_pct) gap++;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= data_byte;
      req_tlast  <= end_of_data;
      do @(posedge clock); while (!req_tready);
      items_sent++;
   endtask

   // Stop sending and let every expected run arrive
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (runs_pending != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // One data block built from runs, zero terminators, broken pairs and noise
   task automatic send_block();
      logic [7:0] bytes [$];
      logic [7:0] c;
      int         target;
      int         n;
      target = ($urandom_range(9) == 0) ? $urandom_range(60, 25) : $urandom_range(24, 1);
      while (bytes.size() < target) begin
         n = $urandom_range(8, 1);
         case ($urandom_range(9))
            0, 1, 2: repeat (n) bytes.push_back(printable_byte());
            3, 4, 5: repeat (n) begin
               bytes.push_back(printable_byte());
               bytes.push_back(NUL_BYTE);
            end
            6: begin
               bytes.push_back(NUL_BYTE);
               if ($urandom_range(1)) bytes.push_back(NUL_BYTE);
            end
            7: begin
               // pair whose second byte is not zero
               bytes.push_back(printable_byte());
               c = 8'($urandom_range(255, 1));
               bytes.push_back(c);
            end
            default: repeat ($urandom_range(3, 1)) begin
               c = 8'($urandom_range(255));
               bytes.push_back(c);
            end
         endcase
      end
      foreach (bytes[i]) send_byte(bytes[i], i == bytes.size() - 1);
   endtask

   // Set the registers while idle, then stream random blocks
   task automatic run_phase(input logic [11:0] min_len, input logic nul_term,
                            input logic [1:0] mode, input int send_idle,
                            input int recv_stall, input int quota);
      int  goal;
      logic paused;
      csr_write(REG_MIN_CHARS, 32'(min_len));
      csr_write(REG_NEED_TERM, 32'(nul_term));
      csr_write(REG_SCAN_MODE, 32'(mode));
      idle_pct  = send_idle;
      stall_pct = recv_stall;
      goal      = items_sent + quota;
      paused    = 1'b0;
      while (items_sent < goal) begin
         if (!paused && items_sent >= goal - quota / 2) begin
            wait_drained();
            paused = 1'b1;
         end
         send_block();
      end
      wait_drained();
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // wide run closed by a zero pair, reset settings
      send_byte("a", 1'b0); send_byte(NUL_BYTE, 1'b0);
      send_byte("b", 1'b0); send_byte(NUL_BYTE, 1'b0);
      send_byte("c", 1'b0); send_byte(NUL_BYTE, 1'b0);
      send_byte(NUL_BYTE, 1'b0); send_byte(NUL_BYTE, 1'b0);
      // ASCII run at the range edges, ended by the first byte above it
      send_byte(CHAR_FIRST, 1'b0); send_byte(CHAR_LAST, 1'b0);
      send_byte("A", 1'b0); send_byte(8'h7F, 1'b0);
      send_byte(8'hFF, 1'b0); send_byte(8'h1F, 1'b0);
      // broken pair given back, open ASCII run reported at end of data
      send_byte("x", 1'b0); send_byte(NUL_BYTE, 1'b0);
      send_byte("y", 1'b0); send_byte("z", 1'b0); send_byte("w", 1'b1);
      // last byte never starts a pair
      send_byte("q", 1'b1);
      send_byte("k", 1'b0); send_byte(NUL_BYTE, 1'b1);
      wait_drained();

      run_phase(12'd3,    1'b0, 2'd3,  0,  0, 250);
      run_phase(12'd1,    1'b1, 2'd3, 69,  0, 250);
      run_phase(12'd2,    1'b0, 2'd1,  0, 69, 200);
      run_phase(12'd0,    1'b1, 2'd2, 28, 28, 200);
      run_phase(12'd4095, 1'b0, 2'd3,  0,  0,  80);
      run_phase(12'd5,    1'b1, 2'd1, 69,  0, 150);
      run_phase(12'd0,    1'b0, 2'd0,  0, 69,  60);
      run_phase(12'd2,    1'b0, 2'd2,  0, 69, 200);
      run_phase(12'd1,    1'b0, 2'd3, 28, 28, 300);

      if (mismatch_count == 0 && runs_pending == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
